/* rtl/tdpt_pkg.sv */
package tdpt_pkg;

   // Sequencer states of the trial division engine.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   // The first odd divisor that is tried, and its square.
   localparam int unsigned FIRST_DIVISOR = 3;
   localparam int unsigned FIRST_SQUARE  = 9;

endpackage

/* rtl/trial_division_prime_test.sv */
// Trial division primality test. Each beat on req_ carries one unsigned number of WIDTH bits, and
// one beat on rsp_ answers it: rsp_is_prime is 1 if the number is prime. Values below 2, the
// value 2 and the other even values are answered without trial division. For an odd value
// the odd divisors 3, 5, 7 and so on are tried while the divisor squared is at most the value.
// For each divisor the remainder comes from a bit-serial restoring divider that shifts in one
// bit of the value per cycle. One number is worked on at a time. The next number is taken as
// soon as a result has moved to the output register, even if that result is still waiting on
// rsp_ready.
module trial_division_prime_test #(
   parameter int WIDTH = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [WIDTH-1:0] req_candidate,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_is_prime
);

   localparam int CNT_W = $clog2(WIDTH);
   localparam int SQ_W  = WIDTH + 3;

   tdpt_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             verdict_ff, verdict_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_prime_ff, rsp_prime_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH-1:0] trial_diff;
   logic             trial_fits;
   logic [WIDTH-1:0] rem_next;
   logic             out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      shift_ff     <= shift_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      cnt_ff       <= cnt_in;
      verdict_ff   <= verdict_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   // One restoring division step: bring down the next bit of the value and subtract the divisor
   // if it fits.
   always_comb begin
      trial      = {rem_ff, shift_ff[WIDTH-1]};
      trial_diff = trial[WIDTH-1:0] - div_ff;
      trial_fits = (trial >= {1'b0, div_ff});
      rem_next   = trial_fits ? trial_diff : trial[WIDTH-1:0];
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      cnt_in       = cnt_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_prime_in = rsp_prime_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               n_in   = req_candidate;
               div_in = WIDTH'(tdpt_pkg::FIRST_DIVISOR);
               sq_in  = SQ_W'(tdpt_pkg::FIRST_SQUARE);
               if (req_candidate < WIDTH'(2)) begin
                  verdict_in = 1'b0;
                  state_in   = tdpt_pkg::ST_RESULT;
               end else if (req_candidate == WIDTH'(2)) begin
                  verdict_in = 1'b1;
                  state_in   = tdpt_pkg::ST_RESULT;
               end else if (!req_candidate[0]) begin
                  verdict_in = 1'b0;
                  state_in   = tdpt_pkg::ST_RESULT;
               end else begin
                  state_in = tdpt_pkg::ST_CHECK;
               end
            end
         end
         tdpt_pkg::ST_CHECK: begin
            // Once the divisor squared passes the value, no factor is left to find.
            if (sq_ff > {3'b000, n_ff}) begin
               verdict_in = 1'b1;
               state_in   = tdpt_pkg::ST_RESULT;
            end else begin
               shift_in = n_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = tdpt_pkg::ST_DIVIDE;
            end
         end
         tdpt_pkg::ST_DIVIDE: begin
            shift_in = {shift_ff[WIDTH-2:0], 1'b0};
            rem_in   = rem_next;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               if (rem_next == '0) begin
                  verdict_in = 1'b0;
                  state_in   = tdpt_pkg::ST_RESULT;
               end else begin
                  // (d + 2) squared is d squared plus 4d plus 4.
                  div_in   = div_ff + WIDTH'(2);
                  sq_in    = sq_ff + {1'b0, div_ff, 2'b00} + SQ_W'(4);
                  state_in = tdpt_pkg::ST_CHECK;
               end
            end
         end
         tdpt_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = verdict_ff;
               state_in     = tdpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

endmodule
